FILE: hdl/mnep_pkg.sv
`default_nettype none
package mnep_pkg;

	localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
	localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
	localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
	localparam logic [7:0] BYTE_SONG_POS     = 8'hF2;
	localparam logic [7:0] BYTE_MTC_QUARTER  = 8'hF1;
	localparam logic [7:0] BYTE_SONG_SELECT  = 8'hF3;
	localparam logic [7:0] STATUS_NONE       = 8'h00;

	localparam logic [3:0] KIND_NOTE_OFF     = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON      = 4'h9;
	localparam logic [3:0] KIND_POLY_PRESS   = 4'hA;
	localparam logic [3:0] KIND_CONTROL      = 4'hB;
	localparam logic [3:0] KIND_PROGRAM      = 4'hC;
	localparam logic [3:0] KIND_CHAN_PRESS   = 4'hD;
	localparam logic [3:0] KIND_PITCH_BEND   = 4'hE;
	localparam logic [3:0] KIND_SYSTEM       = 4'hF;

	typedef struct packed {
		logic       hit;
		logic [3:0] channel;
		logic [6:0] note_number;
		logic       note_on;
	} note_evt_t;

	function automatic logic [1:0] bytes_needed(input logic [7:0] s);
		logic [1:0] n;
		n = 2'd0;
		case (s[7:4])
			KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS, KIND_CONTROL,
			KIND_PITCH_BEND: begin
				n = 2'd2;
			end
			KIND_PROGRAM, KIND_CHAN_PRESS: begin
				n = 2'd1;
			end
			KIND_SYSTEM: begin
				if (s == BYTE_SONG_POS) begin
					n = 2'd2;
				end else if (s == BYTE_MTC_QUARTER || s == BYTE_SONG_SELECT) begin
					n = 2'd1;
				end
			end
			default: begin
				n = 2'd0;
			end
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/midi_note_event_parser.sv
// MIDI note event parser.
// Input channel midi_valid/midi_ready/midi_byte takes one raw byte of the
// serial MIDI stream per item. Output channel note_valid/note_ready carries
// channel, note_number and note_on for each completed Note On or Note Off
// (Note On with velocity 0 reports note_on = 0). All other bytes and
// messages, including real-time bytes and SysEx payload, produce no item.
// A byte is held in an input register, parsed combinationally against the
// running-status state, and its event lands in the output register: note_valid
// rises as the byte advances out of the input register.
// Throughput is one byte per cycle while note_ready is high; the output
// register is the only limit on advancing the input register.
// When note_ready is low with a result pending, the result holds and the
// input register keeps one byte; midi_ready drops once both are full.
// Reset clears running status, SysEx and message state and empties both
// registers. No memories and no clearing pass.
`default_nettype none
module midi_note_event_parser (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        midi_valid,
	output logic       midi_ready,
	input  wire  [7:0] midi_byte,
	output logic       note_valid,
	input  wire        note_ready,
	output logic [3:0] channel,
	output logic [6:0] note_number,
	output logic       note_on
);
	import mnep_pkg::*;

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       adv;
	note_evt_t  evt;

	assign adv        = valid_s1 && (!note_valid || note_ready);
	assign midi_ready = !valid_s1 || adv;

	mnep_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_in (byte_s1),
		.evt     (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			note_valid <= 1'b0;
		end else begin
			if (midi_ready) begin
				valid_s1 <= midi_valid;
			end
			if (adv && evt.hit) begin
				note_valid <= 1'b1;
			end else if (note_ready) begin
				note_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (midi_valid && midi_ready) begin
			byte_s1 <= midi_byte;
		end
		if (adv && evt.hit) begin
			channel     <= evt.channel;
			note_number <= evt.note_number;
			note_on     <= evt.note_on;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mnep_parse.sv
`default_nettype none
module mnep_parse (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  wire  [7:0]            byte_in,
	output mnep_pkg::note_evt_t   evt
);
	import mnep_pkg::*;

	logic [7:0] cur_status_q, run_status_q;
	logic [6:0] first_data_q, second_data_q;
	logic [1:0] rcv_q, exp_q;
	logic       sysex_q;

	logic [7:0] cur_status_d, run_status_d;
	logic [6:0] first_data_d, second_data_d;
	logic [1:0] rcv_d, exp_d;
	logic       sysex_d;

	always_comb begin
		logic [7:0] cs_w;
		logic [1:0] exp_w, rcv_w, rcv_inc, need;
		logic [6:0] fd_w, sd_w;
		logic       ok;
		cur_status_d  = cur_status_q;
		run_status_d  = run_status_q;
		first_data_d  = first_data_q;
		second_data_d = second_data_q;
		rcv_d         = rcv_q;
		exp_d         = exp_q;
		sysex_d       = sysex_q;
		evt           = '0;
		cs_w          = cur_status_q;
		exp_w         = exp_q;
		rcv_w         = rcv_q;
		fd_w          = first_data_q;
		sd_w          = second_data_q;
		ok            = 1'b1;
		rcv_inc       = 2'd0;
		need          = bytes_needed(byte_in);
		if (step && byte_in < BYTE_REALTIME_MIN) begin
			if (byte_in[7]) begin
				if (byte_in == BYTE_SYSEX_START) begin
					sysex_d      = 1'b1;
					run_status_d = STATUS_NONE;
					cur_status_d = STATUS_NONE;
					rcv_d        = 2'd0;
				end else if (byte_in == BYTE_SYSEX_END) begin
					sysex_d      = 1'b0;
					cur_status_d = STATUS_NONE;
					rcv_d        = 2'd0;
				end else begin
					sysex_d      = 1'b0;
					rcv_d        = 2'd0;
					exp_d        = need;
					run_status_d = (byte_in < BYTE_SYSEX_START) ? byte_in : STATUS_NONE;
					cur_status_d = (need == 2'd0) ? STATUS_NONE : byte_in;
				end
			end else if (!sysex_q) begin
				if (cur_status_q == STATUS_NONE) begin
					if (run_status_q == STATUS_NONE) begin
						ok = 1'b0;
					end else begin
						cs_w  = run_status_q;
						exp_w = bytes_needed(run_status_q);
						rcv_w = 2'd0;
					end
				end
				if (ok) begin
					if (rcv_w == 2'd0) begin
						fd_w = byte_in[6:0];
					end else if (rcv_w == 2'd1) begin
						sd_w = byte_in[6:0];
					end
					rcv_inc       = rcv_w + 2'd1;
					first_data_d  = fd_w;
					second_data_d = sd_w;
					exp_d         = exp_w;
					if (rcv_inc >= exp_w) begin
						if (cs_w[7:4] == KIND_NOTE_ON || cs_w[7:4] == KIND_NOTE_OFF) begin
							evt.hit         = 1'b1;
							evt.channel     = cs_w[3:0];
							evt.note_number = fd_w;
							evt.note_on     = (cs_w[7:4] == KIND_NOTE_ON) && (sd_w != 7'd0);
						end
						rcv_d        = 2'd0;
						cur_status_d = run_status_q;
					end else begin
						rcv_d        = rcv_inc;
						cur_status_d = cs_w;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_status_q  <= STATUS_NONE;
			run_status_q  <= STATUS_NONE;
			first_data_q  <= '0;
			second_data_q <= '0;
			rcv_q         <= '0;
			exp_q         <= '0;
			sysex_q       <= 1'b0;
		end else begin
			cur_status_q  <= cur_status_d;
			run_status_q  <= run_status_d;
			first_data_q  <= first_data_d;
			second_data_q <= second_data_d;
			rcv_q         <= rcv_d;
			exp_q         <= exp_d;
			sysex_q       <= sysex_d;
		end
	end

endmodule
`default_nettype wire
